// File: sv/dic_pkg.sv
// ----------------------------------------------------------------------------
// dic_pkg
// Shared types, codes and constants of the double / int64 converter.
// ----------------------------------------------------------------------------
package dic_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned EXP_W  = 11;
   localparam int unsigned FRAC_W = 52;
   localparam int unsigned POS_W  = 6;

   localparam logic [EXP_W-1:0]  EXP_BIAS    = 11'd1023;
   localparam logic [WORD_W-1:0] INT_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [WORD_W-1:0] INT_MIN_NEG = 64'h8000_0000_0000_0000;

   typedef enum logic [1:0] {
      MODE_D2I = 2'd0,
      MODE_S2D = 2'd1,
      MODE_U2D = 2'd2,
      MODE_NOP = 2'd3
   } mode_type;

   // Request held in the input register
   typedef struct packed {
      mode_type          mode;
      logic [WORD_W-1:0] operand;
   } req_type;

endpackage

// File: sv/double_int64_converter.sv
// ----------------------------------------------------------------------------
// double_int64_converter
// Converts between IEEE-754 double bits and signed or unsigned 64-bit ints.
// ----------------------------------------------------------------------------
// channel  ports                         direction
// request  req_valid req_ready req_mode  in
//          req_operand
// response rsp_valid rsp_ready rsp_result out
//
// Two register stages: input register, conversion logic, result register.
// One request per cycle sustained while rsp_ready stays high; each request moves from input to result register.
// The conversion logic (leading-one search and barrel shift) sets the clock.
// Reset clears both valid flags; a stalled response holds the result register and a full input register.
// ----------------------------------------------------------------------------
module double_int64_converter
   import dic_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [WORD_W-1:0] req_operand,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_result
);

   logic              in_vld_ff, in_vld_in;
   req_type           in_ff, in_in;
   logic              out_vld_ff, out_vld_in;
   logic [WORD_W-1:0] out_ff, out_in;
   logic              out_take;
   logic [WORD_W-1:0] int_val, dbl_val, mag;
   logic              sign;

   // Advance when the result register frees or is empty
   assign out_take  = !out_vld_ff || rsp_ready;
   assign req_ready = !in_vld_ff || out_take;

   assign in_vld_in  = req_ready ? req_valid : in_vld_ff;
   assign in_in      = req_ready ? req_type'({req_mode, req_operand}) : in_ff;
   assign out_vld_in = out_take ? in_vld_ff : out_vld_ff;

   dic_to_int u_to_int (.bits(in_ff.operand), .value(int_val));

   // Take the magnitude of a negative signed operand
   assign sign = (in_ff.mode == MODE_S2D) && in_ff.operand[WORD_W-1];
   assign mag  = sign ? (WORD_W'(0) - in_ff.operand) : in_ff.operand;

   dic_to_double u_to_double (.mag(mag), .sign(sign), .value(dbl_val));

   always_comb begin
      out_in = out_ff;
      if (out_take) begin
         unique case (in_ff.mode)
            MODE_D2I: out_in = int_val;
            MODE_S2D: out_in = dbl_val;
            MODE_U2D: out_in = dbl_val;
            default:  out_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_result = out_ff;

`ifndef NO_ASSERTIONS
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_ready |=> out_vld_ff && $stable(out_ff))
      else $error("result changed while stalled");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req_ready)
      else $error("empty input stage not ready");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_take |=> out_vld_ff)
      else $error("request lost between stages");
`endif

endmodule

// File: sv/dic_to_int.sv
// ----------------------------------------------------------------------------
// dic_to_int
// Double bits to signed 64-bit integer, truncating toward zero, saturating.
// ----------------------------------------------------------------------------
module dic_to_int
   import dic_pkg::*;
(
   input  logic [WORD_W-1:0] bits,
   output logic [WORD_W-1:0] value
);

   logic              neg;
   logic [EXP_W-1:0]  exp_raw;
   logic [EXP_W:0]    e;
   logic [WORD_W-1:0] mant;
   logic [WORD_W-1:0] mag;
   logic [POS_W-1:0]  sh;

   assign neg     = bits[WORD_W-1];
   assign exp_raw = bits[WORD_W-2 -: EXP_W];
   assign e       = {1'b0, exp_raw} - {1'b0, EXP_BIAS};
   assign mant    = {{(WORD_W-FRAC_W-1){1'b0}}, 1'b1, bits[FRAC_W-1:0]};
   assign sh      = e[POS_W-1:0];

   // Shift the mantissa into place, then saturate or negate
   always_comb begin
      if (sh > POS_W'(FRAC_W)) begin
         mag = mant << (sh - POS_W'(FRAC_W));
      end else begin
         mag = mant >> (POS_W'(FRAC_W) - sh);
      end
      if (e[EXP_W]) begin
         value = '0;
      end else if (e >= (EXP_W+1)'(63)) begin
         value = neg ? INT_MIN_NEG : INT_MAX_POS;
      end else begin
         value = neg ? (WORD_W'(0) - mag) : mag;
      end
   end

endmodule

// File: sv/dic_to_double.sv
// ----------------------------------------------------------------------------
// dic_to_double
// Integer magnitude to double bits: leading-one search, truncated fraction.
// ----------------------------------------------------------------------------
module dic_to_double
   import dic_pkg::*;
(
   input  logic [WORD_W-1:0] mag,
   input  logic              sign,
   output logic [WORD_W-1:0] value
);

   logic [POS_W-1:0]  top;
   logic [WORD_W-1:0] norm;

   // Find the leading one
   always_comb begin
      top = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (mag[i]) top = POS_W'(i);
      end
   end

   // Move the leading one to bit 63; the next 52 bits form the fraction
   assign norm = mag << (POS_W'(WORD_W-1) - top);

   always_comb begin
      if (mag == '0) begin
         value = '0;
      end else begin
         value = {sign, EXP_BIAS + EXP_W'(top), norm[WORD_W-2 -: FRAC_W]};
      end
   end

endmodule

// File: bench/tb_double_int64_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_int64_converter
// Self-checking bench for the double / int64 converter. Requests are sent
// over the request channel; every response is checked against a predictor
// that converts the same operand, in request order.
// ----------------------------------------------------------------------------
module tb_double_int64_converter;
   import dic_pkg::*;

   localparam int unsigned IDLE_LIMIT = 5000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_mode;
   logic [WORD_W-1:0] req_operand;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [WORD_W-1:0] rsp_result;

   logic [WORD_W-1:0] expected_results[$];
   int unsigned       error_count;
   int unsigned       checked_count;
   int unsigned       sent_count;
   int unsigned       quiet_cycles;
   bit                steady_phase;   // no idling on either side
   bit                rsp_hold;       // ask the receiver to hold off
   bit                rsp_hold_done;

   double_int64_converter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (rsp_result)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Double bits to signed int64, truncating toward zero
   function automatic logic [WORD_W-1:0] double_to_int(logic [WORD_W-1:0] bits);
      int                e;
      logic [WORD_W-1:0] mant;
      logic [WORD_W-1:0] mag;
      e = int'(bits[62:52]) - 1023;
      mant = {12'd0, bits[51:0]} | (64'd1 << 52);
      if (e < 0)
         return '0;
      if (e >= 63)
         return bits[63] ? INT_MIN_NEG : INT_MAX_POS;
      if (e > 52)
         mag = mant << (e - 52);
      else
         mag = mant >> (52 - e);
      return bits[63] ? (64'd0 - mag) : mag;
   endfunction

   // Magnitude to double bits, low bits dropped with no rounding
   function automatic logic [WORD_W-1:0] mag_to_double(logic [WORD_W-1:0] mag,
                                                       logic sign);
      int                top;
      logic [WORD_W-1:0] rest;
      logic [WORD_W-1:0] frac;
      logic [10:0]       expo;
      if (mag == '0)
         return '0;
      top = 63;
      while (!mag[top])
         top--;
      rest = mag ^ (64'd1 << top);
      if (top <= 52)
         frac = rest << (52 - top);
      else
         frac = rest >> (top - 52);
      expo = 11'(top + 1023);
      return {sign, expo, frac[51:0]};
   endfunction

   function automatic logic [WORD_W-1:0] convert(logic [1:0] mode,
                                                 logic [WORD_W-1:0] op);
      case (mode_type'(mode))
         MODE_D2I: return double_to_int(op);
         MODE_S2D: begin
            if (op[63])
               return mag_to_double(64'd0 - op, 1'b1);
            return mag_to_double(op, 1'b0);
         end
         MODE_U2D: return mag_to_double(op, 1'b0);
         default:  return '0;
      endcase
   endfunction

   // Offer one request, idling at random beforehand; hold until accepted
   task automatic send_request(logic [1:0] mode, logic [WORD_W-1:0] op);
      while (!steady_phase && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_operand <= op;
      expected_results.push_back(convert(mode, op));
      do
         @(posedge clock);
      while (!req_ready);
      sent_count++;
   endtask

   // Receiver: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if (rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= steady_phase || ($urandom_range(99) >= 24);
   end

   // Hold the receiver off for a long stretch, counted here
   initial begin
      rsp_hold_done = 1'b0;
      rsp_hold      = 1'b0;
      wait (sent_count >= 300);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (60) @(posedge clock);
      rsp_hold <= 1'b0;
      rsp_hold_done = 1'b1;
   end

   // Check each accepted response against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, actual %h", $realtime, rsp_result);
            error_count++;
         end else begin
            logic [WORD_W-1:0] want;
            want = expected_results.pop_front();
            checked_count++;
            if (rsp_result !== want) begin
               $display("%0t: result mismatch, expected %h actual %h",
                        $realtime, want, rsp_result);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic logic [WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Random double with the exponent near the interesting range
   function automatic logic [WORD_W-1:0] rand_double();
      logic [10:0] expo;
      case ($urandom_range(5))
         0: expo = 11'($urandom);
         1: expo = 11'($urandom_range(1023 + 70, 1023 - 5));
         2: expo = 11'($urandom_range(1023 + 64, 1023 + 61));
         3: expo = $urandom_range(1) ? 11'h7FF : 11'h000;
         default: expo = 11'($urandom_range(1023 + 62, 1023));
      endcase
      return {1'($urandom), expo, 52'(rand64())};
   endfunction

   // Random integer with a random count of significant bits
   function automatic logic [WORD_W-1:0] rand_int();
      int n;
      n = $urandom_range(64);
      if (n == 64)
         return rand64();
      return rand64() & ((64'd1 << n) - 1);
   endfunction

   task automatic test_directed();
      send_request(MODE_D2I, 64'h0000_0000_0000_0000);
      send_request(MODE_D2I, 64'h8000_0000_0000_0001);   // negative subnormal
      send_request(MODE_D2I, 64'h3FE0_0000_0000_0000);   // 0.5
      send_request(MODE_D2I, 64'h3FF0_0000_0000_0000);   // 1.0
      send_request(MODE_D2I, 64'hC00C_0000_0000_0000);   // -3.5
      send_request(MODE_D2I, 64'h4330_0000_0000_0001);   // exponent 52
      send_request(MODE_D2I, 64'h43DF_FFFF_FFFF_FFFF);   // exponent 62
      send_request(MODE_D2I, 64'h43E0_0000_0000_0000);   // exponent 63
      send_request(MODE_D2I, 64'hC3E0_0000_0000_0000);
      send_request(MODE_D2I, 64'h7FF0_0000_0000_0000);   // infinity
      send_request(MODE_D2I, 64'hFFF8_0000_0000_0000);   // NaN
      send_request(MODE_D2I, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(MODE_S2D, 64'd0);
      send_request(MODE_S2D, 64'd1);
      send_request(MODE_S2D, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(MODE_S2D, 64'h8000_0000_0000_0000);   // most negative
      send_request(MODE_S2D, 64'h7FFF_FFFF_FFFF_FFFF);
      send_request(MODE_S2D, 64'h0020_0000_0000_0001);   // drops a low bit
      send_request(MODE_U2D, 64'd0);
      send_request(MODE_U2D, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(MODE_U2D, 64'h8000_0000_0000_0000);
      send_request(MODE_U2D, 64'h0010_0000_0000_0000);
      send_request(MODE_NOP, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(MODE_NOP, 64'h0);
   endtask

   task automatic test_random(int unsigned count);
      logic [1:0] mode;
      for (int unsigned i = 0; i < count; i++) begin
         steady_phase = (i >= 150 && i < 250);
         mode = ($urandom_range(19) == 0) ? MODE_NOP : 2'($urandom_range(2));
         if (mode == MODE_D2I)
            send_request(mode, ($urandom_range(7) == 0) ? rand64() : rand_double());
         else
            send_request(mode, ($urandom_range(7) == 0) ? rand64() : rand_int());
      end
      steady_phase = 1'b0;
   endtask

   // Keep offering requests until the receiver hold-off has run its course
   task automatic test_backpressure();
      steady_phase = 1'b1;
      while (!rsp_hold_done)
         send_request(2'($urandom_range(2)), rand64());
      steady_phase = 1'b0;
   endtask

   initial begin
      error_count   = 0;
      checked_count = 0;
      sent_count    = 0;
      quiet_cycles  = 0;
      steady_phase  = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_mode    = '0;
      req_operand = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(320);
      test_backpressure();
      test_random(460);
      req_valid <= 1'b0;

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d requests in all modes, incl. a long response stall;", sent_count);
      $display("checked %0d responses.", checked_count);
      if (error_count == 0 && expected_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sim.f
sv/dic_pkg.sv
sv/dic_to_int.sv
sv/dic_to_double.sv
sv/double_int64_converter.sv
bench/tb_double_int64_converter.sv
